// ===== rtl/core/thrlf_pkg.sv =====
// ----------------------------------------------------------------------------
// thrlf_pkg
// Types and constants shared by the TLS Client Hello rate limit filter.
// ----------------------------------------------------------------------------
package thrlf_pkg;

	localparam int CountWidth = 32;
	localparam int MaxWidth = 32;
	localparam int CmpWidth = (CountWidth > MaxWidth) ? CountWidth : MaxWidth;
	localparam int PortWidth = 16;
	localparam int TimeWidth = 64;
	localparam int ByteWidth = 8;
	localparam int OffWidth = 8;
	localparam int HdrWidth = 6;
	localparam int CfgDataWidth = 64;

	localparam logic [CountWidth-1:0] CountMax = '1;
	localparam logic [OffWidth-1:0] OffMax = '1;

	localparam logic [OffWidth-1:0] OffEtherTypeHi = 8'd12;
	localparam logic [OffWidth-1:0] OffEtherTypeLo = 8'd13;
	localparam logic [OffWidth-1:0] OffIpVerIhl = 8'd14;
	localparam logic [OffWidth-1:0] OffIpProto = 8'd23;
	localparam logic [OffWidth-1:0] OffTcpEarliest = 8'd34;
	localparam logic [OffWidth-1:0] EthHdrBytes = 8'd14;

	localparam logic [OffWidth-1:0] RelDstPortHi = 8'd2;
	localparam logic [OffWidth-1:0] RelDstPortLo = 8'd3;
	localparam logic [OffWidth-1:0] RelDataOffset = 8'd12;
	localparam logic [OffWidth-1:0] TlsRelContentType = 8'd0;
	localparam logic [OffWidth-1:0] TlsRelHandshakeType = 8'd5;

	localparam logic [HdrWidth-1:0] MinHdrBytes = 6'd20;
	localparam logic [ByteWidth-1:0] EtherTypeIpv4Hi = 8'h08;
	localparam logic [ByteWidth-1:0] EtherTypeIpv4Lo = 8'h00;
	localparam logic [ByteWidth-1:0] IpProtoTcp = 8'd6;
	localparam logic [ByteWidth-1:0] TlsHandshake = 8'd22;
	localparam logic [ByteWidth-1:0] TlsClientHello = 8'd1;

	localparam logic [PortWidth-1:0] WatchPortReset = 16'd6379;
	localparam logic [MaxWidth-1:0] MaxPerWindowReset = 32'd5;
	localparam logic [TimeWidth-1:0] WindowLengthReset = 64'd1000000000;

	typedef enum logic [1:0] {
		CfgWatchPort = 2'd0,
		CfgMaxPerWindow = 2'd1,
		CfgWindowLength = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [PortWidth-1:0] watch_port;
		logic [MaxWidth-1:0] max_per_window;
		logic [TimeWidth-1:0] window_length_ns;
	} cfg_t;

	typedef struct packed {
		logic [ByteWidth-1:0] data_byte;
		logic last_byte;
		logic [TimeWidth-1:0] now_ns;
	} in_item_t;

	typedef struct packed {
		logic drop;
		logic client_hello;
	} verdict_t;

endpackage

// ===== rtl/core/thrlf_in_if.sv =====
// ----------------------------------------------------------------------------
// thrlf_in_if
// Byte channel into the filter: one frame byte per transaction.
// ----------------------------------------------------------------------------
interface thrlf_in_if;
	import thrlf_pkg::*;

	logic valid;
	logic ready;
	logic [ByteWidth-1:0] data_byte;
	logic last_byte;
	logic [TimeWidth-1:0] now_ns;

	modport source(output valid, output data_byte, output last_byte, output now_ns,
		input ready);
	modport sink(input valid, input data_byte, input last_byte, input now_ns,
		output ready);
endinterface

// ===== rtl/core/thrlf_out_if.sv =====
// ----------------------------------------------------------------------------
// thrlf_out_if
// Verdict channel out of the filter: one frame verdict per transaction.
// ----------------------------------------------------------------------------
interface thrlf_out_if;
	logic valid;
	logic ready;
	logic drop;
	logic client_hello;

	modport source(output valid, output drop, output client_hello, input ready);
	modport sink(input valid, input drop, input client_hello, output ready);
endinterface

// ===== rtl/core/tls_hello_rate_limit_filter.sv =====
// ----------------------------------------------------------------------------
// tls_hello_rate_limit_filter
// Byte-serial TLS Client Hello filter with one global fixed-window limiter.
// A last byte waits in the input register until the verdict register can take its verdict.
// Throughput: one byte per cycle but for such a wait; the input and verdict
// registers let a new frame stream in while a verdict waits to be taken.
// Reset: all frame state clears, the window closes and the registers return
// to their defaults (port 6379, limit 5, window 1 s).
// ----------------------------------------------------------------------------
module tls_hello_rate_limit_filter (
	input  logic                  clk,
	input  logic                  arst_n,
	thrlf_in_if.sink              in_ch,
	thrlf_out_if.source           out_ch,
	input  logic                  cfg_we,
	input  thrlf_pkg::cfg_index_t cfg_index,
	input  logic [thrlf_pkg::CfgDataWidth-1:0] cfg_wdata
);
	import thrlf_pkg::*;

	cfg_t cfg_q;
	in_item_t item_s1;
	logic valid_s1;
	logic advance;
	verdict_t verdict;
	logic out_valid_q;
	verdict_t out_q;

	assign advance = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.watch_port <= WatchPortReset;
			cfg_q.max_per_window <= MaxPerWindowReset;
			cfg_q.window_length_ns <= WindowLengthReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgWatchPort: cfg_q.watch_port <= cfg_wdata[PortWidth-1:0];
				CfgMaxPerWindow: cfg_q.max_per_window <= cfg_wdata[MaxWidth-1:0];
				CfgWindowLength: cfg_q.window_length_ns <= cfg_wdata[TimeWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.last_byte <= in_ch.last_byte;
			item_s1.now_ns <= in_ch.now_ns;
		end
	end

	thrlf_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg(cfg_q),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			out_q <= verdict;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.drop = out_q.drop;
	assign out_ch.client_hello = out_q.client_hello;
endmodule

// ===== rtl/core/thrlf_engine.sv =====
// ----------------------------------------------------------------------------
// thrlf_engine
// Per-frame header parser and global fixed-window Client Hello counter.
// ----------------------------------------------------------------------------
module thrlf_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  thrlf_pkg::in_item_t item,
	input  thrlf_pkg::cfg_t     cfg,
	output thrlf_pkg::verdict_t verdict
);
	import thrlf_pkg::*;

	logic [OffWidth-1:0] off_q, off_d;
	logic [HdrWidth-1:0] ip_hdr_q, ip_hdr_d;
	logic [HdrWidth-1:0] tcp_hdr_q, tcp_hdr_d;
	logic [ByteWidth-1:0] port_hi_q, port_hi_d;
	logic cand_q, cand_d;
	logic hello_q, hello_d;
	logic drop_q, drop_d;
	logic win_open_q, win_open_d;
	logic [TimeWidth-1:0] win_start_q, win_start_d;
	logic [CountWidth-1:0] win_count_q, win_count_d;

	logic [OffWidth-1:0] tcp_start;
	logic [OffWidth-1:0] rel;
	logic [OffWidth-1:0] tls_rel;
	logic [HdrWidth-1:0] ip_len;
	logic [HdrWidth-1:0] tcp_len;
	logic [TimeWidth-1:0] elapsed;
	logic in_window;
	logic [ByteWidth-1:0] b;

	always_comb begin
		b = item.data_byte;
		tcp_start = EthHdrBytes + {{(OffWidth-HdrWidth){1'b0}}, ip_hdr_q};
		rel = off_q - tcp_start;
		tls_rel = rel - {{(OffWidth-HdrWidth){1'b0}}, tcp_hdr_q};
		ip_len = {b[3:0], 2'b00};
		tcp_len = {b[7:4], 2'b00};
		elapsed = item.now_ns - win_start_q;
		in_window = win_open_q && (elapsed < cfg.window_length_ns);

		off_d = off_q;
		ip_hdr_d = ip_hdr_q;
		tcp_hdr_d = tcp_hdr_q;
		port_hi_d = port_hi_q;
		cand_d = cand_q;
		hello_d = hello_q;
		drop_d = drop_q;
		win_open_d = win_open_q;
		win_start_d = win_start_q;
		win_count_d = win_count_q;

		if (cand_q) begin
			if (off_q == OffEtherTypeHi) begin
				if (b != EtherTypeIpv4Hi) cand_d = 1'b0;
			end else if (off_q == OffEtherTypeLo) begin
				if (b != EtherTypeIpv4Lo) cand_d = 1'b0;
			end else if (off_q == OffIpVerIhl) begin
				if (ip_len < MinHdrBytes) cand_d = 1'b0;
				else ip_hdr_d = ip_len;
			end else if (off_q == OffIpProto) begin
				if (b != IpProtoTcp) cand_d = 1'b0;
			end else if (off_q >= OffTcpEarliest && off_q >= tcp_start) begin
				if (rel == RelDstPortHi) begin
					port_hi_d = b;
				end else if (rel == RelDstPortLo) begin
					if ({port_hi_q, b} != cfg.watch_port) cand_d = 1'b0;
				end else if (rel == RelDataOffset) begin
					if (tcp_len < MinHdrBytes) cand_d = 1'b0;
					else tcp_hdr_d = tcp_len;
				end else if (rel >= OffWidth'(MinHdrBytes) && tcp_hdr_q >= MinHdrBytes
						&& rel >= {{(OffWidth-HdrWidth){1'b0}}, tcp_hdr_q}) begin
					if (tls_rel == TlsRelContentType) begin
						if (b != TlsHandshake) cand_d = 1'b0;
					end else if (tls_rel == TlsRelHandshakeType) begin
						if (b == TlsClientHello) begin
							hello_d = 1'b1;
							if (in_window) begin
								if (win_count_q != CountMax)
									win_count_d = win_count_q + 1'b1;
								if (CmpWidth'(win_count_d) > CmpWidth'(cfg.max_per_window))
									drop_d = 1'b1;
							end else begin
								win_open_d = 1'b1;
								win_start_d = item.now_ns;
								win_count_d = CountWidth'(1);
							end
						end
						cand_d = 1'b0;
					end
				end
			end
		end

		verdict.drop = drop_d;
		verdict.client_hello = hello_d;

		if (item.last_byte) begin
			off_d = '0;
			ip_hdr_d = '0;
			tcp_hdr_d = '0;
			port_hi_d = '0;
			cand_d = 1'b1;
			hello_d = 1'b0;
			drop_d = 1'b0;
		end else if (off_q != OffMax) begin
			off_d = off_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			ip_hdr_q <= '0;
			tcp_hdr_q <= '0;
			port_hi_q <= '0;
			cand_q <= 1'b1;
			hello_q <= 1'b0;
			drop_q <= 1'b0;
			win_open_q <= 1'b0;
			win_start_q <= '0;
			win_count_q <= '0;
		end else if (step) begin
			off_q <= off_d;
			ip_hdr_q <= ip_hdr_d;
			tcp_hdr_q <= tcp_hdr_d;
			port_hi_q <= port_hi_d;
			cand_q <= cand_d;
			hello_q <= hello_d;
			drop_q <= drop_d;
			win_open_q <= win_open_d;
			win_start_q <= win_start_d;
			win_count_q <= win_count_d;
		end
	end
endmodule

// ===== test/tls_hello_rate_limit_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_hello_rate_limit_filter_test
// Streams Ethernet/IPv4/TCP/TLS frames byte by byte into the filter, predicts
// the verdict of every frame, and checks each verdict transaction in order.
// ----------------------------------------------------------------------------
module tls_hello_rate_limit_filter_test;
	import thrlf_pkg::*;

	localparam int StallLimit = 4000;
	localparam int LongHold = 200;
	localparam int SettleCycles = 4;

	typedef enum int {
		FlawNone,
		FlawEtherHi,
		FlawEtherLo,
		FlawIhl,
		FlawProto,
		FlawPort,
		FlawDataOff,
		FlawContent,
		FlawHandshake
	} flaw_t;

	class frame_verdict_board;
		logic [PortWidth-1:0] port_sel;
		logic [MaxWidth-1:0] hello_limit;
		logic [TimeWidth-1:0] window_len;
		int unsigned offset;
		int unsigned ip_len;
		int unsigned tcp_len;
		logic [7:0] port_hi;
		bit alive;
		bit hello;
		bit drop_it;
		bit win_open;
		logic [TimeWidth-1:0] win_start;
		logic [CountWidth-1:0] win_count;
		verdict_t verdicts_due[$];
		int errors;

		function new();
			port_sel = WatchPortReset;
			hello_limit = MaxPerWindowReset;
			window_len = WindowLengthReset;
			win_open = 0;
			win_start = '0;
			win_count = '0;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			offset = 0;
			ip_len = 0;
			tcp_len = 0;
			port_hi = '0;
			alive = 1;
			hello = 0;
			drop_it = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CfgDataWidth-1:0] value);
			case (idx)
				CfgWatchPort: port_sel = value[PortWidth-1:0];
				CfgMaxPerWindow: hello_limit = value[MaxWidth-1:0];
				CfgWindowLength: window_len = value[TimeWidth-1:0];
				default: ;
			endcase
		endfunction

		function void count_hello(logic [TimeWidth-1:0] now);
			logic [TimeWidth-1:0] age;
			age = now - win_start;
			if (win_open && age < window_len) begin
				if (win_count != CountMax)
					win_count++;
				if (win_count > hello_limit)
					drop_it = 1;
			end else begin
				win_open = 1;
				win_start = now;
				win_count = 1;
			end
		endfunction

		function void scan_byte(int unsigned off, logic [7:0] b, logic [TimeWidth-1:0] now);
			int unsigned tcp_at;
			int unsigned rel;
			int unsigned hlen;
			tcp_at = 14 + ip_len;
			if (off == 12) begin
				if (b != EtherTypeIpv4Hi)
					alive = 0;
				return;
			end
			if (off == 13) begin
				if (b != EtherTypeIpv4Lo)
					alive = 0;
				return;
			end
			if (off == 14) begin
				hlen = b[3:0] * 4;
				if (hlen < 20)
					alive = 0;
				else
					ip_len = hlen;
				return;
			end
			if (off == 23) begin
				if (b != IpProtoTcp)
					alive = 0;
				return;
			end
			if (off < 34 || off < tcp_at)
				return;
			rel = off - tcp_at;
			if (rel == 2) begin
				port_hi = b;
			end else if (rel == 3) begin
				if ({port_hi, b} != port_sel)
					alive = 0;
			end else if (rel == 12) begin
				hlen = b[7:4] * 4;
				if (hlen < 20)
					alive = 0;
				else
					tcp_len = hlen;
			end else if (rel >= 20 && tcp_len >= 20 && rel >= tcp_len) begin
				if (rel - tcp_len == 0) begin
					if (b != TlsHandshake)
						alive = 0;
				end else if (rel - tcp_len == 5) begin
					if (b == TlsClientHello) begin
						hello = 1;
						count_hello(now);
					end
					alive = 0;
				end
			end
		endfunction

		function void take_byte(logic [7:0] b, logic last, logic [TimeWidth-1:0] now);
			verdict_t v;
			if (alive)
				scan_byte(offset, b, now);
			if (last) begin
				v.drop = drop_it;
				v.client_hello = hello;
				verdicts_due.push_back(v);
				clear_frame();
			end else if (offset < 255) begin
				offset++;
			end
		endfunction

		task report(string msg);
			$display("%0t: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_verdict(logic drop, logic client_hello);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				report($sformatf("verdict drop=%0b hello=%0b with none pending", drop,
					client_hello));
				return;
			end
			want = verdicts_due.pop_front();
			if (drop !== want.drop)
				report($sformatf("drop %0b, expected %0b", drop, want.drop));
			if (client_hello !== want.client_hello)
				report($sformatf("client_hello %0b, expected %0b", client_hello,
					want.client_hello));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [CfgDataWidth-1:0] cfg_wdata;

	thrlf_in_if in_ch();
	thrlf_out_if out_ch();

	frame_verdict_board board;
	logic [7:0] frame_bytes[$];
	int hs_pos;
	logic [PortWidth-1:0] cur_port;
	logic [TimeWidth-1:0] clock_ns;
	int unsigned tick_max;
	int unsigned bytes_sent;
	bit idle_on;
	bit long_hold_req;

	tls_hello_rate_limit_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	task automatic send_byte(logic [7:0] b, logic last, logic [TimeWidth-1:0] now);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		in_ch.now_ns <= now;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		board.take_byte(b, last, now);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1,
				(i == hs_pos) ? clock_ns : {$urandom, $urandom});
		if ($urandom_range(0, 29) == 0)
			clock_ns += {$urandom, $urandom};
		else
			clock_ns += 64'($urandom_range(0, tick_max));
	endtask

	task automatic make_frame(flaw_t flaw, int ihl, int doff, int tail);
		int ip_bytes;
		int tcp_bytes;
		logic [15:0] dport;
		logic [7:0] v;
		frame_bytes.delete();
		repeat (12) frame_bytes.push_back(8'($urandom));
		v = EtherTypeIpv4Hi;
		if (flaw == FlawEtherHi)
			v = v ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(v);
		v = EtherTypeIpv4Lo;
		if (flaw == FlawEtherLo)
			v = v ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(v);
		if (flaw == FlawIhl)
			ihl = $urandom_range(0, 4);
		ip_bytes = (ihl < 5) ? 20 : ihl * 4;
		frame_bytes.push_back({4'h4, 4'(ihl)});
		for (int i = 1; i < ip_bytes; i++) begin
			v = 8'($urandom);
			if (i == 9)
				v = (flaw == FlawProto) ? IpProtoTcp ^ 8'($urandom_range(1, 255)) : IpProtoTcp;
			frame_bytes.push_back(v);
		end
		dport = cur_port;
		if (flaw == FlawPort)
			dport = dport ^ 16'($urandom_range(1, 65535));
		if (flaw == FlawDataOff)
			doff = $urandom_range(0, 4);
		tcp_bytes = (doff < 5) ? 20 : doff * 4;
		for (int i = 0; i < tcp_bytes; i++) begin
			v = 8'($urandom);
			if (i == 2)
				v = dport[15:8];
			else if (i == 3)
				v = dport[7:0];
			else if (i == 12)
				v = {4'(doff), 4'($urandom)};
			frame_bytes.push_back(v);
		end
		v = TlsHandshake;
		if (flaw == FlawContent)
			v = v ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(v);
		repeat (4) frame_bytes.push_back(8'($urandom));
		hs_pos = frame_bytes.size();
		v = TlsClientHello;
		if (flaw == FlawHandshake)
			v = v ^ 8'($urandom_range(1, 255));
		frame_bytes.push_back(v);
		repeat (tail) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic make_noise(int len, logic [1:0] fill);
		frame_bytes.delete();
		hs_pos = -1;
		repeat (len) begin
			case (fill)
				2'd1: frame_bytes.push_back(8'h00);
				2'd2: frame_bytes.push_back(8'hFF);
				default: frame_bytes.push_back(8'($urandom));
			endcase
		end
	endtask

	task automatic random_frame();
		int r;
		int ihl;
		int doff;
		int tail;
		r = $urandom_range(0, 99);
		ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		doff = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
		tail = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 260) : $urandom_range(0, 12);
		if (r < 65) begin
			make_frame(FlawNone, ihl, doff, tail);
		end else if (r < 80) begin
			make_frame(flaw_t'($urandom_range(FlawEtherHi, FlawHandshake)), ihl, doff, tail);
		end else if (r < 90) begin
			make_frame(FlawNone, ihl, doff, tail);
			frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
		end else begin
			make_noise($urandom_range(1, 40), 2'd0);
		end
		send_frame();
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CfgDataWidth-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic set_limits(logic [15:0] port, logic [31:0] limit, logic [63:0] len);
		write_reg(CfgWatchPort, 64'(port));
		write_reg(CfgMaxPerWindow, 64'(limit));
		write_reg(CfgWindowLength, len);
		cfg_we <= 1'b0;
		cur_port = port;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				board.check_verdict(out_ch.drop, out_ch.client_hello);
			if (long_hold_req) begin
				long_hold_req = 0;
				stall_left = LongHold;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
			if (quiet >= StallLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_start;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgWatchPort;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		in_ch.now_ns = '0;
		cur_port = WatchPortReset;
		clock_ns = 64'd100;
		tick_max = 10;
		bytes_sent = 0;
		idle_on = 1;
		long_hold_req = 0;
		hs_pos = -1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings: clean hellos, large headers, an overlong frame,
		// every rejected header field, early ends and plain noise.
		make_frame(FlawNone, 5, 5, 0);
		send_frame();
		make_frame(FlawNone, 15, 15, 10);
		send_frame();
		make_frame(FlawNone, 5, 5, 200);
		send_frame();
		for (int f = FlawEtherHi; f <= FlawHandshake; f++) begin
			make_frame(flaw_t'(f), 5, 5, 3);
			send_frame();
		end
		make_frame(FlawNone, 5, 5, 0);
		frame_bytes = frame_bytes[0:hs_pos - 1];
		send_frame();
		make_noise(1, 2'd0);
		send_frame();
		make_noise(20, 2'd1);
		send_frame();
		make_noise(20, 2'd2);
		send_frame();
		// The fourth through seventh hello of the window; the last two exceed the limit.
		repeat (4) begin
			make_frame(FlawNone, 5, 5, 2);
			send_frame();
		end
		clock_ns += 64'd2000000000;
		make_frame(FlawNone, 5, 5, 2);
		send_frame();

		// Short frames while the result side holds off, so the block backs up.
		long_hold_req = 1;
		repeat (30) begin
			make_noise(1, 2'd0);
			send_frame();
		end
		drain();

		// The time difference wraps past the top of the counter.
		set_limits(WatchPortReset, 32'd1, 64'd1000);
		tick_max = 0;
		clock_ns = 64'hFFFF_FFFF_FFFF_FFF0;
		make_frame(FlawNone, 5, 5, 0);
		send_frame();
		clock_ns = 64'h10;
		make_frame(FlawNone, 5, 5, 0);
		send_frame();

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: begin
					set_limits(16'h0000, 32'd0, 64'd1);
					tick_max = 2;
				end
				1: begin
					set_limits(16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
					tick_max = 1000;
				end
				2: begin
					set_limits(16'($urandom), 32'd3, 64'd500);
					tick_max = 100;
				end
				3: begin
					set_limits(16'($urandom), 32'd1, 64'd0);
					tick_max = 10;
				end
				default: begin
					set_limits(16'($urandom), 32'($urandom_range(0, 8)),
						64'($urandom_range(1, 5000)));
					tick_max = 200;
				end
			endcase
			if (phase == 5)
				idle_on = 0;
			clock_ns = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : clock_ns;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 30)
				random_frame();
		end

		drain();
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
